### sv/chacha_pkg.sv
// ----------------------------------------------------------------------------
// ChaCha20 block function package
// Shared word type, state codes, register indexes and the sigma constants.
// ----------------------------------------------------------------------------
package chacha_pkg;

	typedef logic [31:0] word_t;

	// Default number of double rounds (twenty rounds in all)
	localparam int DOUBLE_ROUNDS_DEF = 10;

	// Configuration register indexes
	localparam logic [2:0] REG_KEY_0_1   = 3'd0;
	localparam logic [2:0] REG_KEY_2_3   = 3'd1;
	localparam logic [2:0] REG_KEY_4_5   = 3'd2;
	localparam logic [2:0] REG_KEY_6_7   = 3'd3;
	localparam logic [2:0] REG_NONCE_0_1 = 3'd4;
	localparam logic [2:0] REG_NONCE_2   = 3'd5;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 64;

	// "expand 32-byte k"
	localparam word_t SIGMA [4] = '{
		32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
	};

	// Sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_ROUND = 4'b0010,
		ST_FINAL = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	// Rotate left by a fixed amount
	function automatic word_t rotl(input word_t x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

endpackage

### sv/chacha20_block_function_core.sv
// ----------------------------------------------------------------------------
// ChaCha20 block function core
// Produces one 64-byte keystream block per block counter, as eight word pairs.
// ----------------------------------------------------------------------------
// Usage:
//   Load key and nonce through the write port (cfg_wr_en, cfg_index, cfg_data)
//   while the core is idle. Each word on the input channel (in_valid/in_stall)
//   carries a block counter; the core answers with eight words on the output
//   channel (out_valid/out_stall), pair_index 0..7, last_pair set on the 8th.
// Timing:
//   One quarter-round step (add, xor, rotate) runs on four lanes per cycle;
//   the rounds run one step after another on the shared step datapath. A
//   final addition adds the input state back, then one pair leaves per
//   cycle while the output is not stalled. The core takes one counter at a
//   time: in_stall stays high from the accepting edge until the last pair
//   has been loaded into the output register.
// Reset and stall:
//   arst_n clears key, nonce and the sequencer. A stalled output word holds;
//   the pair sequencer waits until the output register is free.
// ----------------------------------------------------------------------------
module chacha20_block_function_core #(
	parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write port
	input  logic                                cfg_wr_en,
	input  logic [chacha_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [31:0]                         block_counter,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [2:0]                          pair_index,
	output logic [31:0]                         even_word,
	output logic [31:0]                         odd_word,
	output logic                                last_pair
);

	localparam int HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
	localparam int HR_W        = (HALF_ROUNDS > 2) ? $clog2(HALF_ROUNDS) : 1;
	localparam logic [HR_W-1:0] HR_LAST = HR_W'(HALF_ROUNDS - 1);

	// Configuration registers
	logic [63:0]              key_q [4];
	logic [63:0]              nonce01_q;
	chacha_pkg::word_t        nonce2_q;

	// Working state and sequencer
	chacha_pkg::word_t        w_q [16];
	chacha_pkg::word_t        counter_q;
	chacha_pkg::state_t       state_q;
	logic [1:0]               step_q;
	logic [HR_W-1:0]          hr_q;
	logic [2:0]               emit_q;

	// Output register
	logic                     out_valid_q;
	logic [2:0]               pair_index_q;
	chacha_pkg::word_t        even_q;
	chacha_pkg::word_t        odd_q;
	logic                     last_q;

	chacha_pkg::word_t        init_w [16];
	chacha_pkg::word_t        step_w [16];
	chacha_pkg::word_t        next_w [16];
	logic                     in_take;
	logic                     out_free;
	logic                     emit_load;

	assign in_stall  = (state_q != chacha_pkg::ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_load = (state_q == chacha_pkg::ST_EMIT) && out_free;

	// Write configuration; drop writes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			nonce01_q <= '0;
			nonce2_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				chacha_pkg::REG_KEY_0_1:   key_q[0]  <= cfg_data;
				chacha_pkg::REG_KEY_2_3:   key_q[1]  <= cfg_data;
				chacha_pkg::REG_KEY_4_5:   key_q[2]  <= cfg_data;
				chacha_pkg::REG_KEY_6_7:   key_q[3]  <= cfg_data;
				chacha_pkg::REG_NONCE_0_1: nonce01_q <= cfg_data;
				chacha_pkg::REG_NONCE_2:   nonce2_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// Build the input state from constants, key, counter and nonce
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			init_w[i]         = chacha_pkg::SIGMA[i];
			init_w[4 + 2 * i] = key_q[i][31:0];
			init_w[5 + 2 * i] = key_q[i][63:32];
		end
		init_w[12] = counter_q;
		init_w[13] = nonce01_q[31:0];
		init_w[14] = nonce01_q[63:32];
		init_w[15] = nonce2_q;
	end

	// Quarter-round step on four column lanes: x += y; z = rotl(z ^ x)
	// Even steps work on rows a,b,d; odd steps on rows c,d,b.
	always_comb begin
		chacha_pkg::word_t x, y, z, sum, mix, rot;
		x = '0;
		y = '0;
		z = '0;
		sum = '0;
		mix = '0;
		rot = '0;
		for (int i = 0; i < 16; i++) step_w[i] = w_q[i];
		for (int l = 0; l < 4; l++) begin
			if (step_q[0]) begin
				x = w_q[8 + l];
				y = w_q[12 + l];
				z = w_q[4 + l];
			end else begin
				x = w_q[l];
				y = w_q[4 + l];
				z = w_q[12 + l];
			end
			sum = x + y;
			mix = z ^ sum;
			unique case (step_q)
				2'd0: rot = chacha_pkg::rotl(mix, 16);
				2'd1: rot = chacha_pkg::rotl(mix, 12);
				2'd2: rot = chacha_pkg::rotl(mix, 8);
				default: rot = chacha_pkg::rotl(mix, 7);
			endcase
			if (step_q[0]) begin
				step_w[8 + l] = sum;
				step_w[4 + l] = rot;
			end else begin
				step_w[l]      = sum;
				step_w[12 + l] = rot;
			end
		end
	end

	// After the last step of a half round, shift rows so the next half round
	// again works on columns: diagonalise after a column round, undo after a
	// diagonal round.
	always_comb begin
		for (int i = 0; i < 16; i++) next_w[i] = step_w[i];
		if (step_q == 2'd3) begin
			for (int r = 0; r < 4; r++) begin
				for (int j = 0; j < 4; j++) begin
					if (!hr_q[0])
						next_w[4 * r + j] = step_w[4 * r + ((j + r) % 4)];
					else
						next_w[4 * r + j] = step_w[4 * r + ((j + 4 - r) % 4)];
				end
			end
		end
	end

	// Sequencer: load, rounds, final addition, pair emission
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= chacha_pkg::ST_IDLE;
			step_q  <= '0;
			hr_q    <= '0;
			emit_q  <= '0;
		end else begin
			unique case (state_q)
				chacha_pkg::ST_IDLE: begin
					if (in_take) begin
						state_q <= chacha_pkg::ST_ROUND;
						step_q  <= '0;
						hr_q    <= '0;
					end
				end
				chacha_pkg::ST_ROUND: begin
					step_q <= step_q + 2'd1;
					if (step_q == 2'd3) begin
						hr_q <= hr_q + HR_W'(1);
						if (hr_q == HR_LAST) state_q <= chacha_pkg::ST_FINAL;
					end
				end
				chacha_pkg::ST_FINAL: begin
					state_q <= chacha_pkg::ST_EMIT;
					emit_q  <= '0;
				end
				chacha_pkg::ST_EMIT: begin
					if (out_free) begin
						emit_q <= emit_q + 3'd1;
						if (emit_q == 3'd7) state_q <= chacha_pkg::ST_IDLE;
					end
				end
				default: state_q <= chacha_pkg::ST_IDLE;
			endcase
		end
	end

	// Working words: load, advance one step, add input back, shift out pairs
	always_ff @(posedge clk) begin
		if (in_take) begin
			counter_q <= block_counter;
			w_q[12]   <= block_counter;
			for (int i = 0; i < 16; i++) begin
				if (i != 12) w_q[i] <= init_w[i];
			end
		end else if (state_q == chacha_pkg::ST_ROUND) begin
			for (int i = 0; i < 16; i++) w_q[i] <= next_w[i];
		end else if (state_q == chacha_pkg::ST_FINAL) begin
			for (int i = 0; i < 16; i++) w_q[i] <= w_q[i] + init_w[i];
		end else if (emit_load) begin
			for (int i = 0; i < 14; i++) w_q[i] <= w_q[i + 2];
		end
	end

	// Output register: load a pair when free, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			pair_index_q <= emit_q;
			even_q       <= w_q[0];
			odd_q        <= w_q[1];
			last_q       <= (emit_q == 3'd7);
		end
	end

	assign out_valid  = out_valid_q;
	assign pair_index = pair_index_q;
	assign even_word  = even_q;
	assign odd_word   = odd_q;
	assign last_pair  = last_q;

	// An accepted counter starts the first step of the first half round
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |=> (state_q == chacha_pkg::ST_ROUND) && (step_q == 2'd0) && (hr_q == '0))
		else $error("round sequencer did not start cleanly");

	// The last step of the last half round leads to the final addition
	a_rounds_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == chacha_pkg::ST_ROUND) && (step_q == 2'd3) && (hr_q == HR_LAST)
		|=> (state_q == chacha_pkg::ST_FINAL))
		else $error("rounds did not end in the final addition");

	// A pair taken before the last one leaves the sequencer still emitting
	a_more_pairs: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_pair |-> (state_q == chacha_pkg::ST_EMIT))
		else $error("block ended before its last pair");

	// Pair index follows the emit counter, one behind
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		emit_load |=> out_valid && (pair_index == $past(emit_q))
		&& (last_pair == (pair_index == 3'd7)))
		else $error("pair index out of order");

endmodule

### bench/chacha20_keystream_checker.sv
// ----------------------------------------------------------------------------
// ChaCha20 keystream checker
// Watches the write port and both channels of the block function core. For
// every accepted block counter it computes the sixteen keystream words from
// its own copy of the key and nonce registers and compares each output word
// pair with the oldest pair still owed. Counts mismatches for the bench top.
// ----------------------------------------------------------------------------
module chacha20_keystream_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [chacha_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [chacha_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                                in_valid,
	input  logic                                in_stall,
	input  logic [31:0]                         block_counter,
	input  logic                                out_valid,
	input  logic                                out_stall,
	input  logic [2:0]                          pair_index,
	input  logic [31:0]                         even_word,
	input  logic [31:0]                         odd_word,
	input  logic                                last_pair,
	output int                                  fail_count,
	output int                                  pairs_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROUND_PAIRS = chacha_pkg::DOUBLE_ROUNDS_DEF;

	typedef struct packed {
		logic [2:0]        idx;
		chacha_pkg::word_t even;
		chacha_pkg::word_t odd;
		logic              last;
	} keystream_pair_t;

	logic [63:0]       key_nonce_regs [6];
	chacha_pkg::word_t mix_words [16];
	keystream_pair_t   expected_pairs [$];
	int                mismatches;

	// Rotate left through a doubled copy of the word
	function automatic chacha_pkg::word_t rol(input chacha_pkg::word_t x, input int n);
		logic [63:0] both;
		both = {x, x} << n;
		return both[63:32];
	endfunction

	// One quarter round on the working words
	function automatic void mix_quarter(input int a, input int b, input int c, input int d);
		mix_words[a] = mix_words[a] + mix_words[b];
		mix_words[d] = rol(mix_words[d] ^ mix_words[a], 16);
		mix_words[c] = mix_words[c] + mix_words[d];
		mix_words[b] = rol(mix_words[b] ^ mix_words[c], 12);
		mix_words[a] = mix_words[a] + mix_words[b];
		mix_words[d] = rol(mix_words[d] ^ mix_words[a], 8);
		mix_words[c] = mix_words[c] + mix_words[d];
		mix_words[b] = rol(mix_words[b] ^ mix_words[c], 7);
	endfunction

	// Build the block state, run the rounds, add back and queue eight pairs
	task automatic predict_keystream_block(input chacha_pkg::word_t counter);
		chacha_pkg::word_t start_words [16];
		keystream_pair_t   pair;
		for (int i = 0; i < 4; i++) begin
			start_words[i]         = chacha_pkg::SIGMA[i];
			start_words[4 + 2 * i] = key_nonce_regs[i][31:0];
			start_words[5 + 2 * i] = key_nonce_regs[i][63:32];
		end
		start_words[12] = counter;
		start_words[13] = key_nonce_regs[chacha_pkg::REG_NONCE_0_1][31:0];
		start_words[14] = key_nonce_regs[chacha_pkg::REG_NONCE_0_1][63:32];
		start_words[15] = key_nonce_regs[chacha_pkg::REG_NONCE_2][31:0];
		mix_words = start_words;
		repeat (ROUND_PAIRS) begin
			// columns
			mix_quarter(0, 4, 8, 12);
			mix_quarter(1, 5, 9, 13);
			mix_quarter(2, 6, 10, 14);
			mix_quarter(3, 7, 11, 15);
			// diagonals
			mix_quarter(0, 5, 10, 15);
			mix_quarter(1, 6, 11, 12);
			mix_quarter(2, 7, 8, 13);
			mix_quarter(3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			mix_words[i] = mix_words[i] + start_words[i];
		for (int k = 0; k < 8; k++) begin
			pair.idx  = 3'(k);
			pair.even = mix_words[2 * k];
			pair.odd  = mix_words[2 * k + 1];
			pair.last = (k == 7);
			expected_pairs.push_back(pair);
		end
	endtask

	// Track register writes, predict on input words, compare on output words
	always @(posedge clk or negedge arst_n) begin
		keystream_pair_t want;
		if (!arst_n) begin
			for (int r = 0; r < 6; r++)
				key_nonce_regs[r] = '0;
			expected_pairs.delete();
			mismatches = 0;
			fail_count    <= 0;
			pairs_pending <= 0;
		end else begin
			// keep key and nonce; drop writes beyond the list, mask the short one
			if (cfg_wr_en) begin
				if (cfg_index <= chacha_pkg::REG_NONCE_0_1)
					key_nonce_regs[cfg_index] = cfg_data;
				else if (cfg_index == chacha_pkg::REG_NONCE_2)
					key_nonce_regs[chacha_pkg::REG_NONCE_2] = {32'h0, cfg_data[31:0]};
			end

			if (in_valid && !in_stall)
				predict_keystream_block(block_counter);

			if (out_valid && !out_stall) begin
				if (expected_pairs.size() == 0) begin
					$error("output word (pair_index %0d) with no block pending", pair_index);
					mismatches++;
				end else begin
					want = expected_pairs.pop_front();
					if (pair_index !== want.idx) begin
						$error("pair_index: expected %0d, actual %0d", want.idx, pair_index);
						mismatches++;
					end
					if (even_word !== want.even) begin
						$error("even_word: expected %08h, actual %08h", want.even, even_word);
						mismatches++;
					end
					if (odd_word !== want.odd) begin
						$error("odd_word: expected %08h, actual %08h", want.odd, odd_word);
						mismatches++;
					end
					if (last_pair !== want.last) begin
						$error("last_pair: expected %0b, actual %0b", want.last, last_pair);
						mismatches++;
					end
				end
			end

			fail_count    <= mismatches;
			pairs_pending <= expected_pairs.size();
		end
	end

endmodule

### bench/chacha20_block_function_core_tb.sv
// ----------------------------------------------------------------------------
// ChaCha20 block function core testbench
// Loads key and nonce sets (reset values, the standard test vector, extreme
// patterns, random sets) and sends block counters with random gaps while the
// output side stalls at random. A checker beside the core predicts and
// compares every keystream word pair; this top gives the verdict.
// ----------------------------------------------------------------------------
module chacha20_block_function_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 100;
	localparam int RANDOM_SETS  = 5;
	localparam int SET_BLOCKS   = 50;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [31:0] block_counter;
	logic        out_valid;
	logic        out_stall;
	logic [2:0]  pair_index;
	logic [31:0] even_word;
	logic [31:0] odd_word;
	logic        last_pair;
	int          fail_count;
	int          pairs_pending;
	int          cycle_count = 0;
	bit          in_rush = 1'b0;
	logic [63:0] reg_image [6];

	chacha20_block_function_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.block_counter(block_counter),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pair_index   (pair_index),
		.even_word    (even_word),
		.odd_word     (odd_word),
		.last_pair    (last_pair)
	);

	chacha20_keystream_checker keystream_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.block_counter(block_counter),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pair_index   (pair_index),
		.even_word    (even_word),
		.odd_word     (odd_word),
		.last_pair    (last_pair),
		.fail_count   (fail_count),
		.pairs_pending(pairs_pending)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("chacha20_block_function_core verification failed");
			$finish;
		end
	end

	// Write one register at the next edge
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	// Load the register image, then junk at the indexes past the list
	task automatic load_registers();
		for (int r = chacha_pkg::REG_KEY_0_1; r <= chacha_pkg::REG_NONCE_2; r++)
			write_reg(3'(r), reg_image[r]);
		for (int r = chacha_pkg::REG_NONCE_2 + 1; r < 8; r++)
			write_reg(3'(r), {$urandom, $urandom});
		cfg_wr_en <= 1'b0;
	endtask

	// Offer one counter word after a random gap and hold it until taken
	task automatic send_counter(input logic [31:0] value);
		int gap;
		if ($urandom_range(0, 15) == 0)
			in_rush = !in_rush;
		gap = in_rush ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		block_counter <= value;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait until every owed pair has come out
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pairs_pending != 0);
		repeat (4) @(posedge clk);
	endtask

	// Random stalls on the output side, with stretches of none
	initial begin : output_back_pressure
		int  hold;
		bit  out_rush;
		out_stall = 1'b0;
		out_rush  = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0)
				out_rush = !out_rush;
			hold = out_rush ? 0 : $urandom_range(0, 11);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : stimulus
		logic [31:0] counter;
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		block_counter = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero key and nonce straight from reset
		send_counter(32'h0000_0000);
		send_counter(32'hffff_ffff);
		send_counter(32'h0000_0001);
		wait_idle();

		// standard test vector: key 00..1f, nonce 00000009 0000004a 00000000
		reg_image[chacha_pkg::REG_KEY_0_1]   = {32'h0706_0504, 32'h0302_0100};
		reg_image[chacha_pkg::REG_KEY_2_3]   = {32'h0f0e_0d0c, 32'h0b0a_0908};
		reg_image[chacha_pkg::REG_KEY_4_5]   = {32'h1716_1514, 32'h1312_1110};
		reg_image[chacha_pkg::REG_KEY_6_7]   = {32'h1f1e_1d1c, 32'h1b1a_1918};
		reg_image[chacha_pkg::REG_NONCE_0_1] = {32'h4a00_0000, 32'h0900_0000};
		reg_image[chacha_pkg::REG_NONCE_2]   = 64'h0;
		load_registers();
		send_counter(32'h0000_0001);
		send_counter(32'h0000_0000);
		send_counter(32'h7fff_ffff);
		send_counter(32'h8000_0000);
		send_counter(32'haaaa_aaaa);
		send_counter(32'h5555_5555);
		wait_idle();

		// all ones, with junk above the short register
		for (int r = chacha_pkg::REG_KEY_0_1; r <= chacha_pkg::REG_NONCE_2; r++)
			reg_image[r] = '1;
		load_registers();
		send_counter(32'hffff_ffff);
		send_counter(32'hffff_fffe);
		send_counter(32'h0000_0000);
		wait_idle();

		// alternating bit patterns
		for (int r = chacha_pkg::REG_KEY_0_1; r <= chacha_pkg::REG_NONCE_2; r++)
			reg_image[r] = r[0] ? 64'h5a5a_5a5a_a5a5_a5a5 : 64'ha5a5_a5a5_5a5a_5a5a;
		load_registers();
		send_counter(32'h0f0f_0f0f);
		send_counter(32'hf0f0_f0f0);
		send_counter(32'h0000_0002);
		wait_idle();

		// random key and nonce sets, each with a run of random counters
		for (int s = 0; s < RANDOM_SETS; s++) begin
			for (int r = chacha_pkg::REG_KEY_0_1; r <= chacha_pkg::REG_NONCE_2; r++) begin
				case ($urandom_range(0, 5))
					0:       reg_image[r] = '0;
					1:       reg_image[r] = '1;
					default: reg_image[r] = {$urandom, $urandom};
				endcase
			end
			load_registers();
			for (int n = 0; n < SET_BLOCKS; n++) begin
				case ($urandom_range(0, 7))
					0:       counter = 32'hffff_ffff - $urandom_range(0, 3);
					1:       counter = $urandom_range(0, 3);
					default: counter = $urandom;
				endcase
				send_counter(counter);
			end
			wait_idle();
		end

		// let any stray output show up before the verdict
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pairs_pending == 0) begin
			$display("chacha20_block_function_core verification clean");
		end else begin
			$display("chacha20_block_function_core verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/chacha_pkg.sv
sv/chacha20_block_function_core.sv
bench/chacha20_keystream_checker.sv
bench/chacha20_block_function_core_tb.sv
